[src/ccr_pkg.sv]
// Shared types, codes and constants of the coat-check key registry.
package ccr_pkg;

  // Field widths and default table depth
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DEPTH_DEF = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Request item
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   req_key;
    logic [VALUE_W-1:0] new_value;
  } ccr_req_t;

  // Result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [VALUE_W-1:0]  out_value;
  } ccr_rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REPLY,
    CS_SEARCH_RD,
    CS_SEARCH_CMP,
    CS_SHIFT
  } ccr_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rd_mid;
    logic cmp;
    logic shift_init;
    logic shift;
    logic reply;
  } ccr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              search_open;
    logic              hit;
    logic              shift_more;
  } ccr_stat_t;

endpackage

[src/ccr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ccr_ctrl.sv]
// Controller state machine of the coat-check key registry.
module ccr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ccr_pkg::FUNC_W-1:0] func_i,
  input  ccr_pkg::ccr_stat_t        stat_i,
  output ccr_pkg::ccr_cmd_t         cmd_o,
  output logic                      busy_o
);
  import ccr_pkg::*;

  ccr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (func_i == OP_GET || func_i == OP_REMOVE) begin
            state_d = CS_SEARCH_RD;
          end else begin
            state_d = CS_REPLY;
          end
        end
      end
      CS_REPLY: begin
        cmd_o.reply = 1'b1;
        state_d     = CS_IDLE;
      end
      CS_SEARCH_RD: begin
        priority if (stat_i.search_open) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = CS_SEARCH_CMP;
        end else if (stat_i.op == OP_REMOVE && stat_i.hit) begin
          cmd_o.shift_init = 1'b1;
          state_d          = CS_SHIFT;
        end else begin
          cmd_o.reply = 1'b1;
          state_d     = CS_IDLE;
        end
      end
      CS_SEARCH_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = CS_SEARCH_RD;
      end
      CS_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.reply = 1'b1;
          state_d     = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != CS_IDLE);

`ifndef ASSERT_OFF
  // A compaction only follows a search that found its key
  a_shift_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift_init |-> stat_i.op == OP_REMOVE && stat_i.hit)
    else $error("compaction started without a hit");
  // Shifting only happens while removing
  a_shift_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_SHIFT) |-> stat_i.op == OP_REMOVE)
    else $error("shift state outside a remove");
  // An accepted item makes the block busy in the next cycle
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_o)
    else $error("item accepted but block not busy");
`endif

endmodule

[src/ccr_datapath.sv]
// Datapath of the coat-check key registry: table, search, compaction, result.
module ccr_datapath #(
  parameter int unsigned DEPTH = ccr_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccr_pkg::ccr_req_t  req_i,
  input  ccr_pkg::ccr_cmd_t  cmd_i,
  output ccr_pkg::ccr_stat_t stat_o,
  output ccr_pkg::ccr_rsp_t  rsp_o,
  output logic               strobe_o
);
  import ccr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = KEY_W + VALUE_W;

  ccr_req_t             req_q;
  logic [CW-1:0]        lo_q, hi_q, pos_q, count_q;
  logic [KEY_W-1:0]     next_key_q;
  logic                 hit_q;
  logic [VALUE_W-1:0]   val_q;
  ccr_rsp_t             rsp_q;
  logic                 strobe_q;

  logic [CW-1:0]        mid, hi_plus1, pos_plus1, pos_plus2;
  logic                 full;
  logic                 do_insert;
  logic                 do_drop;
  logic [KEY_W-1:0]     rd_key;
  logic [VALUE_W-1:0]   rd_val;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  ccr_rsp_t             rsp_d;

  // Search midpoint and pointers
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign hi_plus1  = hi_q + CW'(1);
  assign pos_plus1 = pos_q + CW'(1);
  assign pos_plus2 = pos_q + CW'(2);

  assign full      = (count_q == CW'(DEPTH)) || (next_key_q == '1);
  assign do_insert = cmd_i.reply && (req_q.func == OP_INSERT) && !full;
  assign do_drop   = cmd_i.reply && (req_q.func == OP_REMOVE) && hit_q;

  assign rd_key = ram_rdata[DW-1:VALUE_W];
  assign rd_val = ram_rdata[VALUE_W-1:0];

  // Status to the controller
  assign stat_o.op          = req_q.func;
  assign stat_o.search_open = (lo_q < hi_q);
  assign stat_o.hit         = hit_q;
  assign stat_o.shift_more  = (pos_plus1 < count_q);

  // Table port selection
  always_comb begin
    ram_re    = cmd_i.rd_mid || cmd_i.shift_init || cmd_i.shift;
    priority if (cmd_i.shift) begin
      ram_raddr = pos_plus2[AW-1:0];
    end else if (cmd_i.shift_init) begin
      ram_raddr = hi_plus1[AW-1:0];
    end else begin
      ram_raddr = mid[AW-1:0];
    end
    ram_we = do_insert || cmd_i.shift;
    if (cmd_i.shift) begin
      ram_waddr = pos_q[AW-1:0];
      ram_wdata = ram_rdata;
    end else begin
      ram_waddr = count_q[AW-1:0];
      ram_wdata = {next_key_q, req_q.new_value};
    end
  end

  ccr_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold the request and the search window
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      lo_q  <= '0;
      hi_q  <= count_q;
      hit_q <= 1'b0;
      val_q <= '0;
    end else if (cmd_i.cmp) begin
      if (rd_key < req_q.req_key) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q  <= mid;
        hit_q <= (rd_key == req_q.req_key);
        val_q <= rd_val;
      end
    end
  end

  // Advance the compaction pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_init) begin
      pos_q <= hi_q;
    end else if (cmd_i.shift) begin
      pos_q <= pos_plus1;
    end
  end

  // Live count and key counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      next_key_q <= '0;
    end else if (do_insert) begin
      count_q    <= count_q + CW'(1);
      next_key_q <= next_key_q + KEY_W'(1);
    end else if (do_drop) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Form the result item
  always_comb begin
    rsp_d = '0;
    unique case (req_q.func)
      OP_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.out_key = next_key_q;
        end
      end
      OP_GET: begin
        if (hit_q) begin
          rsp_d.out_value = val_q;
        end else begin
          rsp_d.status = ST_MISSING;
        end
      end
      OP_REMOVE: begin
        if (!hit_q) begin
          rsp_d.status = ST_MISSING;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.reply;
    end
  end

  assign rsp_o    = rsp_q;
  assign strobe_o = strobe_q;

`ifndef ASSERT_OFF
  // The live count never exceeds the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("live count beyond table depth");
  // A successful insert grows the table by one
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the table");
  // Compaction stays inside the live entries
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> hit_q && (pos_q < count_q))
    else $error("compaction outside live entries");
  // Results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("back-to-back result strobes");
`endif

endmodule

[src/coat_check_key_registry.sv]
// Coat-check key registry: top level joining controller, datapath and table.
// From acceptance to result: insert and unused go straight to the reply state;
//   get does S search steps of one table read each, S at most ceil(log2(L+1)), L live.
//   Remove adds compaction after a hit at slot p: L-1-p entries moved, one per cycle.
// Throughput: one item at a time; the next item is taken at the edge that takes the result.
// Reset clears live count, key counter and controller, not the table; receiver cannot stall.
module coat_check_key_registry #(
  parameter int unsigned DEPTH = ccr_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ccr_pkg::ccr_req_t req_i,
  output ccr_pkg::ccr_rsp_t rsp_o,
  output logic              strobe_o
);
  import ccr_pkg::*;

  ccr_cmd_t  cmd;
  ccr_stat_t stat;

  ccr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (req_i.func),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ccr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .rsp_o    (rsp_o),
    .strobe_o (strobe_o)
  );

`ifndef ASSERT_OFF
  // A result is only shown while the controller is back at rest
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while busy");
  // Every accepted item makes the block busy, with no result shown, in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !strobe_o)
    else $error("accepted item not held");
  // A result always ends a busy period
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result without work");
`endif

endmodule

[sim/coat_check_key_registry_tb.sv]
// Self-checking testbench of the coat-check key registry: directed and random items.
module coat_check_key_registry_tb;
  import ccr_pkg::*;

  localparam int unsigned REG_DEPTH   = ccr_pkg::DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned MAX_GAP     = 40;
  // Function code that the block has no use for
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  logic     clk_i;
  logic     rst_n;
  logic     start_q;
  logic     busy;
  ccr_req_t req_q;
  ccr_rsp_t rsp;
  logic     strobe;

  // Shadow copy of the registry contents
  logic [KEY_W-1:0]   shadow_keys [REG_DEPTH];
  logic [VALUE_W-1:0] shadow_vals [REG_DEPTH];
  int unsigned        shadow_count;
  logic [KEY_W-1:0]   shadow_next_key;

  ccr_rsp_t    replies_due [$];
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned sender_idle_pct;

  coat_check_key_registry #(
    .DEPTH (REG_DEPTH)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_n),
    .start    (start_q),
    .busy     (busy),
    .req_i    (req_q),
    .rsp_o    (rsp),
    .strobe_o (strobe)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // Lower-bound search over the live, key-sorted part of the shadow table
  function automatic int unsigned first_not_below(input logic [KEY_W-1:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one item to the shadow table and return the reply it earns
  function automatic ccr_rsp_t apply_to_shadow_table(input ccr_req_t item);
    ccr_rsp_t    reply;
    int unsigned pos;
    bit          hit;
    reply = '0;
    reply.status = ST_OK;
    pos = first_not_below(item.req_key);
    hit = (pos < shadow_count) && (shadow_keys[pos] == item.req_key);
    case (item.func)
      OP_INSERT: begin
        if (shadow_count >= REG_DEPTH || shadow_next_key == '1) begin
          reply.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = shadow_next_key;
          shadow_vals[shadow_count] = item.new_value;
          shadow_count++;
          reply.out_key = shadow_next_key;
          shadow_next_key = shadow_next_key + 1'b1;
        end
      end
      OP_GET: begin
        if (hit) reply.out_value = shadow_vals[pos];
        else reply.status = ST_MISSING;
      end
      OP_REMOVE: begin
        if (hit) begin
          // close the gap so the table stays dense
          while (pos + 1 < shadow_count) begin
            shadow_keys[pos] = shadow_keys[pos + 1];
            shadow_vals[pos] = shadow_vals[pos + 1];
            pos++;
          end
          shadow_count--;
        end else begin
          reply.status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Offer one item, after a random idle gap, and hold it until accepted
  task automatic send_item(input ccr_req_t item);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_q <= 1'b1;
    req_q   <= item;
    do @(posedge clk_i); while (busy);
    replies_due.push_back(apply_to_shadow_table(item));
  endtask

  function automatic ccr_req_t make_item(input logic [FUNC_W-1:0] func,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] value);
    ccr_req_t item;
    item.func      = func;
    item.req_key   = key;
    item.new_value = value;
    return item;
  endfunction

  // Drop start and wait for every outstanding reply
  task automatic drain_replies();
    start_q <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Check each reply against the oldest one due
  always @(posedge clk_i) begin
    ccr_rsp_t want;
    if (rst_n && strobe === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no item outstanding");
      end else begin
        want = replies_due.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.out_key !== want.out_key)
          report_mismatch($sformatf("out_key got %h want %h", rsp.out_key, want.out_key));
        if (rsp.out_value !== want.out_value)
          report_mismatch($sformatf("out_value got %h want %h",
                                    rsp.out_value, want.out_value));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_n || (start_q && !busy) || strobe === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item or reply for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Empty table, missing keys at both key extremes, unused function, value extremes
  task automatic test_basic_ops();
    sender_idle_pct = 0;
    send_item(make_item(OP_GET, '0, 8'h5a));
    send_item(make_item(OP_REMOVE, '1, 8'hff));
    send_item(make_item(OP_UNUSED, '1, 8'hff));
    send_item(make_item(OP_INSERT, '0, 8'h00));
    send_item(make_item(OP_INSERT, '1, 8'hff));
    send_item(make_item(OP_GET, 32'd1, 8'h00));
    send_item(make_item(OP_GET, 32'd0, 8'hff));
    send_item(make_item(OP_GET, '1, 8'h00));
    send_item(make_item(OP_REMOVE, 32'd0, 8'h00));
    send_item(make_item(OP_GET, 32'd0, 8'h00));
    send_item(make_item(OP_REMOVE, 32'd0, 8'h00));
  endtask

  // Fill the table, hit the full status, then remove at the ends and middle
  task automatic test_table_full();
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] last_key;
    sender_idle_pct = 0;
    while (shadow_count < REG_DEPTH)
      send_item(make_item(OP_INSERT, $urandom(), VALUE_W'($urandom_range(255))));
    send_item(make_item(OP_INSERT, '0, 8'ha5));
    first_key = shadow_keys[0];
    last_key  = shadow_keys[REG_DEPTH-1];
    send_item(make_item(OP_GET, last_key, 8'h00));
    send_item(make_item(OP_REMOVE, shadow_keys[REG_DEPTH/2], 8'h00));
    send_item(make_item(OP_REMOVE, first_key, 8'h00));
    send_item(make_item(OP_REMOVE, last_key, 8'h00));
    send_item(make_item(OP_INSERT, '0, 8'h3c));
  endtask

  // Random mix steered by the fill level, mostly aimed at live keys
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
    ccr_req_t    item;
    int unsigned pick;
    int unsigned roll;
    int unsigned insert_pct;
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      item.req_key   = $urandom();
      item.new_value = VALUE_W'($urandom_range(255));
      insert_pct = (shadow_count >= REG_DEPTH) ? 10 : (shadow_count < 4) ? 55 : 35;
      pick = $urandom_range(99);
      if (pick < insert_pct) begin
        item.func = OP_INSERT;
      end else if (pick < 95) begin
        item.func = $urandom_range(1) ? OP_GET : OP_REMOVE;
        roll = $urandom_range(99);
        if (roll < 65 && shadow_count > 0)
          item.req_key = shadow_keys[$urandom_range(shadow_count - 1)];
        else if (roll < 85)
          item.req_key = shadow_next_key - KEY_W'($urandom_range(8));
      end else begin
        item.func = OP_UNUSED;
      end
      send_item(item);
    end
  endtask

  // Reset, then run the tests in turn
  initial begin
    rst_n           <= 1'b0;
    start_q         <= 1'b0;
    req_q           <= '0;
    mismatches      = 0;
    stall_cycles    = 0;
    sender_idle_pct = 0;
    shadow_count    = 0;
    shadow_next_key = '0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_table_full();
    drain_replies();
    test_random_traffic(220, 0);
    drain_replies();
    test_random_traffic(150, 74);
    drain_replies();
    test_random_traffic(150, 6);
    drain_replies();
    test_random_traffic(100, 0);
    drain_replies();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
src/ccr_pkg.sv
src/ccr_ram.sv
src/ccr_ctrl.sv
src/ccr_datapath.sv
src/coat_check_key_registry.sv
sim/coat_check_key_registry_tb.sv
